FILE: src/isqs_pkg.sv
`default_nettype none
package isqs_pkg;

   localparam logic [2:0] OP_APPEND      = 3'd0;
   localparam logic [2:0] OP_REMOVE_LAST = 3'd1;
   localparam logic [2:0] OP_INSERT      = 3'd2;
   localparam logic [2:0] OP_ERASE       = 3'd3;
   localparam logic [2:0] OP_READ        = 3'd4;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   typedef logic signed [31:0] data_type;

   typedef struct packed {
      logic ins;
      logic ers;
      logic app;
   } cell_ctl_type;

endpackage
`default_nettype wire

FILE: src/isqs_if.sv
`default_nettype none
interface isqs_req_if;
   logic                valid;
   logic                ready;
   logic [2:0]          operation;
   logic [4:0]          position;
   logic signed [31:0]  data_value;

   modport source (output valid, output operation, output position, output data_value,
                   input ready);
   modport sink   (input valid, input operation, input position, input data_value,
                   output ready);
endinterface

interface isqs_rsp_if;
   logic                valid;
   logic                ready;
   logic [1:0]          status;
   logic signed [31:0]  read_value;
   logic [4:0]          element_count;

   modport source (output valid, output status, output read_value, output element_count,
                   input ready);
   modport sink   (input valid, input status, input read_value, input element_count,
                   output ready);
endinterface
`default_nettype wire

FILE: src/indexed_sequence_store_unit.sv
`default_nettype none
// channel  dir  beat
// req      in   operation, position, data_value
// rsp      out  status, read_value, element_count
//
// One beat per cycle while rsp drains: every operation finishes at the edge it is taken,
// insert and erase shift every cell from the given position upward at that same clock edge.
// The response sits in an output register, valid from the next cycle; req is
// taken while it is empty or being drained, so a stalled rsp holds req back
// after one beat.
// Reset clears the count and the response valid; cell contents stay undefined
// until written.
module indexed_sequence_store_unit #(
   parameter int DEPTH = 16
) (
   input wire logic    clock,
   input wire logic    reset,
   isqs_req_if.sink    req_bus,
   isqs_rsp_if.source  rsp_bus
);

   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int PW     = (CNT_W > 5) ? CNT_W : 5;
   localparam int RD_N   = (DEPTH < 32) ? DEPTH : 32;
   localparam int RSEL_W = $clog2(RD_N);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_status_ff;
   isqs_pkg::data_type rsp_value_ff;
   logic [4:0]       rsp_count_ff;

   logic             accept;
   logic [PW-1:0]    pos_ext;
   logic [PW-1:0]    cnt_ext;
   logic [PW-1:0]    cnt_next_ext;
   logic             full;
   logic [1:0]       status;
   isqs_pkg::data_type rd_value;
   isqs_pkg::cell_ctl_type ctl;

   isqs_pkg::data_type cell_data [DEPTH];
   isqs_pkg::data_type rd_taps [RD_N];

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign pos_ext       = PW'(req_bus.position);
   assign cnt_ext       = PW'(count_ff);
   assign full          = (count_ff == CNT_W'(DEPTH));

   always_comb begin
      status   = isqs_pkg::ST_BAD;
      rd_value = '0;
      ctl      = '0;
      count_in = count_ff;
      case (req_bus.operation)
         isqs_pkg::OP_APPEND: begin
            if (full) begin
               status = isqs_pkg::ST_FULL;
            end else begin
               status   = isqs_pkg::ST_DONE;
               ctl.app  = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         isqs_pkg::OP_REMOVE_LAST: begin
            if (count_ff != '0) begin
               status   = isqs_pkg::ST_DONE;
               count_in = count_ff - CNT_W'(1);
            end
         end
         isqs_pkg::OP_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status = isqs_pkg::ST_BAD;
            end else if (full) begin
               status = isqs_pkg::ST_FULL;
            end else begin
               status   = isqs_pkg::ST_DONE;
               ctl.ins  = accept;
               count_in = count_ff + CNT_W'(1);
            end
         end
         isqs_pkg::OP_ERASE: begin
            if (pos_ext < cnt_ext) begin
               status   = isqs_pkg::ST_DONE;
               ctl.ers  = accept;
               count_in = count_ff - CNT_W'(1);
            end
         end
         isqs_pkg::OP_READ: begin
            if (pos_ext < cnt_ext) begin
               status   = isqs_pkg::ST_DONE;
               rd_value = rd_taps[req_bus.position[RSEL_W-1:0]];
            end
         end
         default: begin
            status = isqs_pkg::ST_BAD;
         end
      endcase
   end

   assign cnt_next_ext = PW'(count_in);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      isqs_pkg::data_type left_v;
      isqs_pkg::data_type right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_data[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_data[i+1];
      end
      isqs_cell #(
         .IDX (i),
         .PW  (PW)
      ) u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .pos         (pos_ext),
         .tail        (cnt_ext),
         .ins_value   (req_bus.data_value),
         .left_value  (left_v),
         .right_value (right_v),
         .cell_value  (cell_data[i])
      );
   end

   for (genvar j = 0; j < RD_N; j++) begin : g_tap
      assign rd_taps[j] = cell_data[j];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff <= status;
         rsp_value_ff  <= rd_value;
         rsp_count_ff  <= cnt_next_ext[4:0];
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.status        = rsp_status_ff;
   assign rsp_bus.read_value    = rsp_value_ff;
   assign rsp_bus.element_count = rsp_count_ff;

endmodule
`default_nettype wire

FILE: src/isqs_cell.sv
`default_nettype none
module isqs_cell #(
   parameter int IDX = 0,
   parameter int PW  = 5
) (
   input  wire logic                  clock,
   input  wire isqs_pkg::cell_ctl_type ctl,
   input  wire logic [PW-1:0]         pos,
   input  wire logic [PW-1:0]         tail,
   input  wire isqs_pkg::data_type    ins_value,
   input  wire isqs_pkg::data_type    left_value,
   input  wire isqs_pkg::data_type    right_value,
   output      isqs_pkg::data_type    cell_value
);

   localparam logic [PW-1:0] MyIdx = PW'(IDX);

   isqs_pkg::data_type value_ff;
   isqs_pkg::data_type value_in;

   always_comb begin
      value_in = value_ff;
      if (ctl.ins) begin
         if (MyIdx == pos) begin
            value_in = ins_value;
         end else if (MyIdx > pos) begin
            value_in = left_value;
         end
      end
      if (ctl.ers && (MyIdx >= pos)) begin
         value_in = right_value;
      end
      if (ctl.app && (MyIdx == tail)) begin
         value_in = ins_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule
`default_nettype wire
